// File: src/fot_pkg.sv
// Package for the fetch outstanding tracker: tick and result item types, depth defaults.
// Used by every module of the block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fot_pkg;
   localparam int STAGE_DEPTH_DEF = 4;
   localparam int OST_DEPTH_DEF   = 4;

   typedef struct packed {
      logic        fetch_valid;
      logic [31:0] fetch_pc;
      logic        bus_rsp_valid;
      logic [31:0] bus_rsp_data;
      logic        bus_rsp_ok;
      logic        expt_valid;
      logic [31:0] expt_pc;
      logic [5:0]  expt_cause;
      logic [1:0]  expt_priv;
      logic [31:0] expt_tval;
      logic        bus_req_ready;
      logic        fetch_rsp_ready;
   } req_type;

   typedef struct packed {
      logic        fetch_accepted;
      logic        bus_req_valid;
      logic [31:0] bus_req_addr;
      logic        resp_valid;
      logic [31:0] resp_instr;
      logic        resp_ok;
      logic        resp_expt;
      logic [5:0]  resp_cause;
      logic [1:0]  resp_priv;
      logic [31:0] resp_tval;
      logic        protocol_error;
   } rsp_type;

   // Front-to-back hand-off: one tick with the staging decision already made.
   typedef struct packed {
      req_type     tick;
      logic        accept;
   } front_type;
endpackage
`default_nettype wire

// File: src/fot_back.sv
// Back part of the fetch outstanding tracker: staging FIFO, outstanding table, result build.
// Depends on fot_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fot_back #(
   parameter int STAGE_DEPTH = fot_pkg::STAGE_DEPTH_DEF,
   parameter int OST_DEPTH   = fot_pkg::OST_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fot_pkg::front_type in_item,
   input  wire logic              in_valid,
   output fot_pkg::rsp_type       out_item,
   output logic [$clog2(STAGE_DEPTH+1)-1:0] stage_count
);
   localparam int SW = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;
   localparam int OW = (OST_DEPTH > 1) ? $clog2(OST_DEPTH) : 1;
   localparam int CW = $clog2(STAGE_DEPTH + 1);

   logic [31:0]   stage_pc_ff [STAGE_DEPTH];
   logic [CW-1:0] stage_count_ff, stage_count_in;
   logic [SW-1:0] stage_head_ff, stage_head_in;
   logic [OST_DEPTH-1:0] slot_valid_ff, slot_valid_in, slot_done_ff, slot_done_in;
   logic [31:0]   slot_pc_ff [OST_DEPTH];
   logic [31:0]   slot_instr_ff [OST_DEPTH];
   logic          slot_ok_ff [OST_DEPTH];
   logic          slot_expt_ff [OST_DEPTH];
   logic [5:0]    slot_cause_ff [OST_DEPTH];
   logic [1:0]    slot_priv_ff [OST_DEPTH];
   logic [31:0]   slot_tval_ff [OST_DEPTH];
   logic [OW-1:0] table_head_ff, table_head_in, table_tail_ff, table_tail_in;

   fot_pkg::req_type t;
   logic [SW-1:0] wr_idx;
   logic [OW-1:0] ex_idx, rs_idx, k_idx;
   logic          ex_hit, rs_hit, ret, iss, do_acc;
   logic [OST_DEPTH-1:0] wait_mask;
   fot_pkg::rsp_type r;

   assign stage_count = stage_count_ff;

   function automatic logic [SW-1:0] swrap(input logic [SW:0] v);
      logic [SW:0] d;
      d = v;
      if (d >= (SW+1)'(STAGE_DEPTH)) d = d - (SW+1)'(STAGE_DEPTH);
      return d[SW-1:0];
   endfunction
   function automatic logic [OW-1:0] owrap(input logic [OW:0] v);
      logic [OW:0] d;
      d = v;
      if (d >= (OW+1)'(OST_DEPTH)) d = d - (OW+1)'(OST_DEPTH);
      return d[OW-1:0];
   endfunction

   always_comb begin
      t      = in_item.tick;
      do_acc = in_valid && in_item.accept;
      wr_idx = swrap({1'b0, stage_head_ff} + (SW+1)'(stage_count_ff));
      stage_count_in = stage_count_ff + CW'(do_acc);
      wait_mask = slot_valid_ff & ~slot_done_ff;
      ex_hit = 1'b0; ex_idx = '0;
      for (int k = OST_DEPTH - 1; k >= 0; k--) begin
         k_idx = owrap({1'b0, table_head_ff} + (OW+1)'(k));
         if (wait_mask[k_idx] && slot_pc_ff[k_idx] == t.expt_pc) begin
            ex_hit = 1'b1; ex_idx = k_idx;
         end
      end
      ex_hit = ex_hit && in_valid && t.expt_valid;
      rs_hit = 1'b0; rs_idx = '0;
      for (int k = OST_DEPTH - 1; k >= 0; k--) begin
         k_idx = owrap({1'b0, table_head_ff} + (OW+1)'(k));
         if (wait_mask[k_idx] && !(ex_hit && k_idx == ex_idx)) begin
            rs_hit = 1'b1; rs_idx = k_idx;
         end
      end
      rs_hit = rs_hit && in_valid && t.bus_rsp_valid;
      slot_done_in = slot_done_ff;
      if (ex_hit) slot_done_in[ex_idx] = 1'b1;
      if (rs_hit) slot_done_in[rs_idx] = 1'b1;
      slot_valid_in = slot_valid_ff;
      r = '0;
      ret = in_valid && t.fetch_rsp_ready && slot_valid_ff[table_head_ff]
            && slot_done_in[table_head_ff];
      table_head_in = table_head_ff;
      if (ret) begin
         r.resp_valid = 1'b1;
         if (rs_hit && rs_idx == table_head_ff) begin
            r.resp_instr = t.bus_rsp_data; r.resp_ok = t.bus_rsp_ok;
         end else if (ex_hit && ex_idx == table_head_ff) begin
            r.resp_expt = 1'b1; r.resp_cause = t.expt_cause;
            r.resp_priv = t.expt_priv; r.resp_tval = t.expt_tval;
         end else begin
            r.resp_instr = slot_instr_ff[table_head_ff]; r.resp_ok = slot_ok_ff[table_head_ff];
            r.resp_expt  = slot_expt_ff[table_head_ff];
            r.resp_cause = slot_cause_ff[table_head_ff];
            r.resp_priv  = slot_priv_ff[table_head_ff];
            r.resp_tval  = slot_tval_ff[table_head_ff];
         end
         slot_valid_in[table_head_ff] = 1'b0;
         slot_done_in[table_head_ff]  = 1'b0;
         table_head_in = owrap({1'b0, table_head_ff} + (OW+1)'(1));
      end
      iss = in_valid && stage_count_in != '0 && !slot_valid_in[table_tail_ff]
            && t.bus_req_ready;
      stage_head_in = stage_head_ff;
      table_tail_in = table_tail_ff;
      if (iss) begin
         r.bus_req_valid = 1'b1;
         // A PC taken in this same tick may be the only one staged.
         r.bus_req_addr = (stage_count_ff == '0) ? t.fetch_pc : stage_pc_ff[stage_head_ff];
         stage_head_in  = swrap({1'b0, stage_head_ff} + (SW+1)'(1));
         stage_count_in = stage_count_in - CW'(1);
         slot_valid_in[table_tail_ff] = 1'b1;
         slot_done_in[table_tail_ff]  = 1'b0;
         table_tail_in = owrap({1'b0, table_tail_ff} + (OW+1)'(1));
      end
      r.fetch_accepted = do_acc;
      r.protocol_error = in_valid && ((t.expt_valid && !ex_hit) || (t.bus_rsp_valid && !rs_hit));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_count_ff <= '0; stage_head_ff <= '0;
         slot_valid_ff <= '0; slot_done_ff <= '0;
         table_head_ff <= '0; table_tail_ff <= '0;
      end else begin
         stage_count_ff <= stage_count_in; stage_head_ff <= stage_head_in;
         slot_valid_ff <= slot_valid_in; slot_done_ff <= slot_done_in;
         table_head_ff <= table_head_in; table_tail_ff <= table_tail_in;
      end
      out_item <= r;
      if (do_acc) stage_pc_ff[wr_idx] <= t.fetch_pc;
      if (iss) slot_pc_ff[table_tail_ff] <= r.bus_req_addr;
      if (ex_hit) begin
         slot_instr_ff[ex_idx] <= '0; slot_ok_ff[ex_idx] <= 1'b0;
         slot_expt_ff[ex_idx] <= 1'b1; slot_cause_ff[ex_idx] <= t.expt_cause;
         slot_priv_ff[ex_idx] <= t.expt_priv; slot_tval_ff[ex_idx] <= t.expt_tval;
      end
      if (rs_hit) begin
         slot_instr_ff[rs_idx] <= t.bus_rsp_data; slot_ok_ff[rs_idx] <= t.bus_rsp_ok;
         slot_expt_ff[rs_idx] <= 1'b0; slot_cause_ff[rs_idx] <= '0;
         slot_priv_ff[rs_idx] <= '0; slot_tval_ff[rs_idx] <= '0;
      end
   end
endmodule
`default_nettype wire

// File: src/fot_front.sv
// Front part of the fetch outstanding tracker: takes ticks, decides staging acceptance.
// Depends on fot_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fot_front #(
   parameter int STAGE_DEPTH = fot_pkg::STAGE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fot_pkg::req_type  req_item,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [$clog2(STAGE_DEPTH+1)-1:0] stage_count,
   input  wire logic              back_busy,
   output fot_pkg::front_type     out_item,
   output logic                   out_valid
);
   fot_pkg::front_type item_ff;
   logic               valid_ff;

   // One tick is held here; the back part consumes it in the next cycle.
   assign full      = back_busy;
   assign out_item  = item_ff;
   assign out_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= push && !full;
      end
      item_ff.tick   <= req_item;
      item_ff.accept <= req_item.fetch_valid &&
                        ({1'b0, stage_count} < ($clog2(STAGE_DEPTH+1)+1)'(STAGE_DEPTH));
   end
endmodule
`default_nettype wire

// File: src/fetch_outstanding_tracker.sv
// Top level of the fetch outstanding tracker: front, back and output queue.
// Depends on fot_pkg, fot_front and fot_back.
//
// Usage: each input item is one bus/fetch tick (req_ channel, push/full).
// The block answers every tick with one result item (rsp_ channel,
// empty/pop) giving fetch acceptance, the issued bus read, the in-order
// fetch response and the protocol error flag.
// A tick is registered in the front part, then in the back part, and its
// result is then written into the output queue. A tick's staging decision
// needs the fill level that the previous tick leaves, so the next tick is
// taken only once the previous result has reached the output queue.
// A two-entry result queue sits at the output; full is high while a tick
// is in flight or the queue holds two results, so one waiting result does
// not block the next tick and a stalled receiver stops input without loss.
// Reset (synchronous, active high) empties the staging FIFO, the
// outstanding table and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module fetch_outstanding_tracker #(
   parameter int STAGE_DEPTH = fot_pkg::STAGE_DEPTH_DEF,
   parameter int OST_DEPTH   = fot_pkg::OST_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire fot_pkg::req_type req_item,
   output logic                  empty,
   input  wire logic             pop,
   output fot_pkg::rsp_type      rsp_item
);
   fot_pkg::front_type f_item;
   logic               f_valid, back_busy;
   fot_pkg::rsp_type   b_item;
   logic [$clog2(STAGE_DEPTH+1)-1:0] stage_count;
   fot_pkg::rsp_type   q_ff [2];
   logic [1:0]         cnt_ff, cnt_in;
   logic               b_valid_ff, rd_ff, rd_in;

   // Busy while a tick is in flight or the queue could not take its result.
   assign back_busy = f_valid || b_valid_ff || (cnt_ff == 2'd2);

   fot_front #(.STAGE_DEPTH(STAGE_DEPTH)) u_front (
      .clock, .reset, .req_item, .push, .full, .stage_count,
      .back_busy, .out_item(f_item), .out_valid(f_valid)
   );
   fot_back #(.STAGE_DEPTH(STAGE_DEPTH), .OST_DEPTH(OST_DEPTH)) u_back (
      .clock, .reset, .in_item(f_item), .in_valid(f_valid),
      .out_item(b_item), .stage_count
   );

   assign empty    = (cnt_ff == 2'd0);
   assign rsp_item = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(b_valid_ff) - 2'(pop && !empty);
      rd_in  = rd_ff ^ (pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; b_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; rd_ff <= rd_in; b_valid_ff <= f_valid;
      end
      // The new result goes behind whatever the queue holds before this edge.
      if (b_valid_ff) q_ff[rd_ff ^ cnt_ff[0]] <= b_item;
   end
endmodule
`default_nettype wire

// File: src/fot_checker.sv
// Port-level checker for the fetch outstanding tracker, bound to the top level.
// Depends on fot_pkg and fetch_outstanding_tracker.
`timescale 1ns / 1ps
`default_nettype none
module fot_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             push,
   input wire logic             full,
   input wire logic             empty,
   input wire logic             pop,
   input wire fot_pkg::rsp_type rsp_item
);
   a_accept_push: assert property (@(posedge clock) disable iff (reset)
      push && !full |=> full) else $error("full did not rise after an item");
   a_no_issue_full: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item.resp_valid == 1'b0 |-> rsp_item.resp_expt == 1'b0)
      else $error("exception flag without response");
   a_expt_not_ok: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item.resp_expt |-> !rsp_item.resp_ok && rsp_item.resp_instr == '0)
      else $error("exception response carries data");
   a_idle_empty: assert property (@(posedge clock)
      $past(reset) |-> empty) else $error("result present right after reset");
endmodule
bind fetch_outstanding_tracker fot_checker u_fot_checker (
   .clock, .reset, .push, .full, .empty, .pop, .rsp_item
);
`default_nettype wire
